// ----- hdl/sjs_pkg.sv -----
// Shared types and constants for the stratified jitter sampler.
// No dependencies; imported by the front end, back end and top level.
package sjs_pkg;

  localparam int GRID_MAX_DEF  = 256;
  localparam int MID_DEPTH     = 2;
  localparam int OUT_DEPTH     = 4;
  localparam int unsigned ONE_Q16 = 65536;
  localparam int COORD_W       = 18;
  localparam int JIT_W         = 16;
  localparam int RECIP_W       = 17;
  localparam int SIZE_W        = 9;
  localparam int SQ_W          = 33;
  localparam int R2_W          = 35;
  localparam logic [R2_W-1:0] R2_LIMIT = R2_W'(64'h1_0000_0000);

  typedef enum logic [1:0] {
    CFG_GRID_SIZE  = 2'd0,
    CFG_GRID_RECIP = 2'd1,
    CFG_SHAPE_MODE = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    SHAPE_SQUARE = 2'd0,
    SHAPE_CUBE   = 2'd1,
    SHAPE_DISK   = 2'd2,
    SHAPE_BALL   = 2'd3
  } shape_t;

  // Classification of one request, decided in the front end
  typedef struct packed {
    logic done_item;
    logic last;
    logic three_d;
    logic round_shape;
  } sjs_flags_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      final_cell;
    logic                      exhausted;
  } sjs_result_t;

endpackage

// ----- hdl/sjs_fifo.sv -----
// Small register FIFO used between front and back end and for results.
// Depends on nothing; DEPTH must be a power of two, at least 2.
module sjs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               din,
  output logic                       full,
  input  logic                       pop,
  output logic [W-1:0]               dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [W-1:0]     mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign dout    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (!do_push && do_pop) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= din;
  end

endmodule

// ----- hdl/sjs_front.sv -----
// Front end: accepts jitter requests, walks the nested cell counters and
// classifies each request for the back end. Uses sjs_pkg.
module sjs_front
  import sjs_pkg::*;
#(
  parameter int GRID_MAX = GRID_MAX_DEF,
  localparam int CW = $clog2(GRID_MAX)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              q_full,
  input  logic [SIZE_W-1:0] grid_size,
  input  logic [1:0]        shape_mode,
  output logic              q_push,
  output sjs_flags_t        q_flags,
  output logic [CW-1:0]     q_cell_x,
  output logic [CW-1:0]     q_cell_y,
  output logic [CW-1:0]     q_cell_z
);

  localparam int NW = $clog2(GRID_MAX+1);

  logic [CW-1:0] cell_x_r, cell_y_r, cell_z_r;
  logic [CW-1:0] cell_x_nxt, cell_y_nxt, cell_z_nxt;
  logic          grid_done_r;
  logic [NW-1:0] n;
  logic          accept;
  logic          three_d, round_shape;
  logic          wrap_x, wrap_y, wrap_z;
  logic          last;
  shape_t        mode;

  assign mode        = shape_t'(shape_mode);
  assign three_d     = (mode == SHAPE_CUBE) || (mode == SHAPE_BALL);
  assign round_shape = (mode == SHAPE_DISK) || (mode == SHAPE_BALL);
  assign accept      = in_push && !q_full;

  // clamp strata count to [1, GRID_MAX]
  always_comb begin
    priority if (grid_size == '0)              n = NW'(1);
    else if (32'(grid_size) > 32'(GRID_MAX))   n = NW'(GRID_MAX);
    else                                       n = NW'(grid_size);
  end

  assign wrap_x = (32'(cell_x_r) + 32'd1) >= 32'(n);
  assign wrap_y = (32'(cell_y_r) + 32'd1) >= 32'(n);
  assign wrap_z = (32'(cell_z_r) + 32'd1) >= 32'(n);

  // innermost axis advances first; carry ripples outward
  always_comb begin
    cell_x_nxt = cell_x_r;
    cell_y_nxt = cell_y_r;
    cell_z_nxt = cell_z_r;
    last       = 1'b0;
    if (three_d) begin
      cell_z_nxt = wrap_z ? '0 : CW'(cell_z_r + 1'b1);
      if (wrap_z) begin
        cell_y_nxt = wrap_y ? '0 : CW'(cell_y_r + 1'b1);
        if (wrap_y) begin
          cell_x_nxt = wrap_x ? '0 : CW'(cell_x_r + 1'b1);
          last       = wrap_x;
        end
      end
    end else begin
      cell_y_nxt = wrap_y ? '0 : CW'(cell_y_r + 1'b1);
      if (wrap_y) begin
        cell_x_nxt = wrap_x ? '0 : CW'(cell_x_r + 1'b1);
        last       = wrap_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_x_r    <= '0;
      cell_y_r    <= '0;
      cell_z_r    <= '0;
      grid_done_r <= 1'b0;
    end else if (accept && !grid_done_r) begin
      cell_x_r <= cell_x_nxt;
      cell_y_r <= cell_y_nxt;
      cell_z_r <= cell_z_nxt;
      if (last) grid_done_r <= 1'b1;
    end
  end

  assign q_push              = accept;
  assign q_flags.done_item   = grid_done_r;
  assign q_flags.last        = last && !grid_done_r;
  assign q_flags.three_d     = three_d;
  assign q_flags.round_shape = round_shape;
  assign q_cell_x            = cell_x_r;
  assign q_cell_y            = cell_y_r;
  assign q_cell_z            = cell_z_r;

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    grid_done_r |=> grid_done_r)
    else $error("grid done flag dropped without reset");

  a_last_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !grid_done_r && last) |=> grid_done_r)
    else $error("last cell did not finish the grid");

endmodule

// ----- hdl/sjs_back.sv -----
// Back end: scales cell positions by 1/n, maps to [-1,1] for round shapes,
// tests the radius and queues results. Uses sjs_pkg and sjs_fifo.
module sjs_back
  import sjs_pkg::*;
#(
  parameter int GRID_MAX = GRID_MAX_DEF,
  localparam int CW = $clog2(GRID_MAX)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mid_empty,
  output logic               mid_pop,
  input  sjs_flags_t         h_flags,
  input  logic [CW-1:0]      h_cell_x,
  input  logic [CW-1:0]      h_cell_y,
  input  logic [CW-1:0]      h_cell_z,
  input  logic [JIT_W-1:0]   h_jitter_x,
  input  logic [JIT_W-1:0]   h_jitter_y,
  input  logic [JIT_W-1:0]   h_jitter_z,
  input  logic [RECIP_W-1:0] grid_reciprocal,
  input  logic               out_pop,
  output logic               out_empty,
  output sjs_result_t        out_res
);

  localparam int PW    = CW + JIT_W + RECIP_W;
  localparam int CNT_W = $clog2(OUT_DEPTH+1);

  function automatic logic [COORD_W-1:0] map_coord(input logic [PW-1:0] prod,
                                                   input logic          round_shape);
    logic [PW-17:0] shifted;
    logic [16:0]    u;
    logic [18:0]    m;
    shifted = prod[PW-1:16];
    u = (32'(shifted) > ONE_Q16) ? 17'(ONE_Q16) : shifted[16:0];
    m = round_shape ? ({1'b0, u, 1'b0} - 19'(ONE_Q16)) : {2'b00, u};
    return m[COORD_W-1:0];
  endfunction

  // stage 1: scaled positions
  logic          v1_r;
  sjs_flags_t    f1_r;
  logic [PW-1:0] px1_r, py1_r, pz1_r;
  // stage 2: coordinates and squares
  logic                      v2_r;
  sjs_flags_t                f2_r;
  logic signed [COORD_W-1:0] cx2_r, cy2_r, cz2_r;
  logic [SQ_W-1:0]           sqx2_r, sqy2_r, sqz2_r;

  logic signed [COORD_W-1:0] cx, cy, cz;
  logic signed [35:0]        sqx, sqy, sqz;
  logic [R2_W-1:0]           r2;
  logic                      in_sphere, keep, push_out;
  sjs_result_t               res;
  logic                      out_full;
  logic [CNT_W-1:0]          out_count;

  // hold back issue unless the result queue can absorb every item in flight
  assign mid_pop = !mid_empty &&
                   ((32'(out_count) + 32'(v1_r) + 32'(v2_r)) < 32'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= mid_pop;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_r  <= h_flags;
    px1_r <= PW'({h_cell_x, h_jitter_x}) * PW'(grid_reciprocal);
    py1_r <= PW'({h_cell_y, h_jitter_y}) * PW'(grid_reciprocal);
    pz1_r <= PW'({h_cell_z, h_jitter_z}) * PW'(grid_reciprocal);
  end

  assign cx  = $signed(map_coord(px1_r, f1_r.round_shape));
  assign cy  = $signed(map_coord(py1_r, f1_r.round_shape));
  assign cz  = f1_r.three_d ? $signed(map_coord(pz1_r, f1_r.round_shape)) : '0;
  assign sqx = cx * cx;
  assign sqy = cy * cy;
  assign sqz = cz * cz;

  always_ff @(posedge clk) begin
    f2_r   <= f1_r;
    cx2_r  <= cx;
    cy2_r  <= cy;
    cz2_r  <= cz;
    sqx2_r <= SQ_W'(sqx);
    sqy2_r <= SQ_W'(sqy);
    sqz2_r <= SQ_W'(sqz);
  end

  assign r2        = R2_W'(sqx2_r) + R2_W'(sqy2_r) + R2_W'(sqz2_r);
  assign in_sphere = (r2 <= R2_LIMIT);
  assign keep      = !f2_r.round_shape || in_sphere;
  // drop rejected cells unless they close the grid; finished-grid requests always pass
  assign push_out  = v2_r && (f2_r.done_item || keep || f2_r.last);

  always_comb begin
    res = '0;
    priority if (f2_r.done_item) begin
      res.exhausted = 1'b1;
    end else if (!keep) begin
      res.final_cell = 1'b1;
      res.exhausted  = 1'b1;
    end else begin
      res.coord_x    = cx2_r;
      res.coord_y    = cy2_r;
      res.coord_z    = cz2_r;
      res.final_cell = f2_r.last;
    end
  end

  sjs_fifo #(
    .W     ($bits(sjs_result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push_out),
    .din   (res),
    .full  (out_full),
    .pop   (out_pop),
    .dout  (out_res),
    .empty (out_empty),
    .count (out_count)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_out |-> !out_full)
    else $error("result queue overflow");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(out_count) + 32'(v1_r) + 32'(v2_r)) <= 32'(OUT_DEPTH))
    else $error("items in flight exceed result queue space");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && f2_r.done_item) |-> (push_out && res.exhausted && !res.final_cell))
    else $error("finished-grid request lost its result");

endmodule

// ----- hdl/stratified_jitter_sampler_unit.sv -----
// Stratified jitter sampler, top level. One request per cycle sustained
// while results are popped, set by the two-stage multiply pipeline and a
// 4-entry result queue that grants issue credit. Rejected cells produce no
// result unless they close the grid.
// Synchronous active-low reset clears the cell counters, the done flag, both
// queues and restores the configuration defaults; no clearing pass.
module stratified_jitter_sampler_unit
  import sjs_pkg::*;
#(
  parameter int GRID_MAX = GRID_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [JIT_W-1:0]          in_jitter_x,
  input  logic [JIT_W-1:0]          in_jitter_y,
  input  logic [JIT_W-1:0]          in_jitter_z,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic signed [COORD_W-1:0] out_coord_x,
  output logic signed [COORD_W-1:0] out_coord_y,
  output logic signed [COORD_W-1:0] out_coord_z,
  output logic                      out_final_cell,
  output logic                      out_exhausted,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [RECIP_W-1:0]        cfg_data
);

  localparam int CW    = $clog2(GRID_MAX);
  localparam int MID_W = $bits(sjs_flags_t) + 3*CW + 3*JIT_W;

  logic [SIZE_W-1:0]  grid_size_r;
  logic [RECIP_W-1:0] grid_recip_r;
  logic [1:0]         shape_mode_r;

  logic              q_push, mid_full, mid_empty, mid_pop;
  sjs_flags_t        q_flags, h_flags;
  logic [CW-1:0]     q_cell_x, q_cell_y, q_cell_z;
  logic [CW-1:0]     h_cell_x, h_cell_y, h_cell_z;
  logic [JIT_W-1:0]  h_jitter_x, h_jitter_y, h_jitter_z;
  logic [MID_W-1:0]  mid_din, mid_dout;
  sjs_result_t       out_res;

  // refuse writes while reset is held
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r  <= SIZE_W'(1);
      grid_recip_r <= RECIP_W'(ONE_Q16);
      shape_mode_r <= SHAPE_SQUARE;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_GRID_SIZE:  grid_size_r  <= cfg_data[SIZE_W-1:0];
        CFG_GRID_RECIP: grid_recip_r <= cfg_data;
        CFG_SHAPE_MODE: shape_mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // report full while reset is held so no request looks accepted
  assign in_full = mid_full || !rst_n;

  sjs_front #(
    .GRID_MAX (GRID_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .q_full     (mid_full),
    .grid_size  (grid_size_r),
    .shape_mode (shape_mode_r),
    .q_push     (q_push),
    .q_flags    (q_flags),
    .q_cell_x   (q_cell_x),
    .q_cell_y   (q_cell_y),
    .q_cell_z   (q_cell_z)
  );

  assign mid_din = {q_flags, q_cell_x, q_cell_y, q_cell_z,
                    in_jitter_x, in_jitter_y, in_jitter_z};

  sjs_fifo #(
    .W     (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (mid_din),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty),
    .count ()
  );

  assign {h_flags, h_cell_x, h_cell_y, h_cell_z,
          h_jitter_x, h_jitter_y, h_jitter_z} = mid_dout;

  sjs_back #(
    .GRID_MAX (GRID_MAX)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .mid_empty       (mid_empty),
    .mid_pop         (mid_pop),
    .h_flags         (h_flags),
    .h_cell_x        (h_cell_x),
    .h_cell_y        (h_cell_y),
    .h_cell_z        (h_cell_z),
    .h_jitter_x      (h_jitter_x),
    .h_jitter_y      (h_jitter_y),
    .h_jitter_z      (h_jitter_z),
    .grid_reciprocal (grid_recip_r),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_res         (out_res)
  );

  assign out_coord_x    = out_res.coord_x;
  assign out_coord_y    = out_res.coord_y;
  assign out_coord_z    = out_res.coord_z;
  assign out_final_cell = out_res.final_cell;
  assign out_exhausted  = out_res.exhausted;

endmodule
